/* design/lrpe_pkg.sv */
// shared types, constants and helpers for the label row packet encoder
package lrpe_pkg;

  localparam int unsigned MaxRowBytes = 48;
  localparam logic [7:0]  SyncHead    = 8'h55;
  localparam logic [7:0]  SyncTail    = 8'hAA;
  localparam logic [7:0]  RunLimit    = 8'd255;

  typedef enum logic [1:0] {
    CFG_ROW_BYTES,
    CFG_PRINTHEAD,
    CFG_CMD_BITMAP,
    CFG_CMD_EMPTY
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_EMIT
  } top_state_e;

  typedef enum logic [1:0] {
    EM_IDLE,
    EM_RD,
    EM_OUT
  } emit_state_e;

  typedef struct packed {
    logic        blank;
    logic [7:0]  cmd;
    logic [7:0]  pay_len;
    logic [15:0] start_row;
    logic [7:0]  cnt0;
    logic [7:0]  cnt1;
    logic [7:0]  cnt2;
    logic [7:0]  run_len;
  } pkt_desc_t;

  typedef struct packed {
    logic busy;
    logic done;
  } emit_stat_t;

  function automatic logic [3:0] popcount8(input logic [7:0] v);
    logic [3:0] c;
    c = '0;
    for (int i = 0; i < 8; i++) begin
      c = c + 4'(v[i]);
    end
    return c;
  endfunction

  // pixels / 24 == (pixels >> 3) / 3, the divide by 3 as a reciprocal multiply
  function automatic logic [4:0] third_of(input logic [8:0] pixels);
    logic [13:0] prod;
    prod = 14'(pixels[8:3]) * 14'd171;
    return prod[13:9];
  endfunction

endpackage

/* design/label_row_packet_encoder.sv */
// top level: row tracking, run state and the two row banks
//
//  port group   direction  handshake          payload
//  in           sink       in_valid/in_stall  func, pixel_byte
//  out          source     out_valid/out_stall out_byte, last_of_packet
//  cfg          sink       cfg_valid/cfg_ready cfg_index, cfg_data
//
// a pixel beat is a ram read of the run bank, then a compare and update
// a packet is sent byte by byte, with one ram read and one output load per byte
// rows are double-banked; a per-entry bank select flips on a new run instead of copying
// in_stall is high while a beat is compared or a packet is being sent
// reset clears all control state; row bank contents are undefined until written
module label_row_packet_encoder #(
  parameter int unsigned MAX_ROW_BYTES = lrpe_pkg::MaxRowBytes
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       func_i,
  input  logic [7:0] pixel_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       last_of_packet_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [8:0] cfg_data_i
);
  import lrpe_pkg::*;

  localparam int unsigned AW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int unsigned PW = $clog2(MAX_ROW_BYTES + 1);

  logic [5:0] row_bytes_q;
  logic [8:0] ph_q;
  logic [7:0] cmd_bm_q, cmd_em_q;

  top_state_e      st_q, st_d;
  logic            run_open_q, run_open_d;
  logic            run_blank_q, run_blank_d;
  logic [7:0]      run_len_q, run_len_d;
  logic [15:0]     run_start_q, run_start_d;
  logic [15:0]     row_cnt_q, row_cnt_d;
  logic [PW-1:0]   pos_q, pos_d;
  logic            match_q, match_d;
  logic            zero_q, zero_d;
  logic [3:0][8:0] run_cnt_q, run_cnt_d;
  logic [3:0][8:0] inc_cnt_q, inc_cnt_d;
  // bank that holds each run entry, and entries rewritten since the run opened
  logic [MAX_ROW_BYTES-1:0] run_bank_q, run_bank_d;
  logic [MAX_ROW_BYTES-1:0] fresh_q, fresh_d;
  logic            rsel_q;
  logic            eoi_q, eoi_d;
  logic [7:0]      b_q, b_d;

  logic            accept, wr_en, wr_to1, emit_start, do_install, joins;
  logic [PW-1:0]   eff_len, np;
  logic [4:0]      third;
  logic [6:0]      third7, third2_7, third3_7, pos7, eff7;
  logic [1:0]      seg;
  logic [3:0]      pc;
  logic [7:0]      rd0, rd1, rd_run;
  logic [AW-1:0]   emit_addr, raddr;
  logic            split;
  pkt_desc_t       desc;
  emit_stat_t      emit_stat;

  // configuration
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_bytes_q <= 6'd48;
      ph_q        <= 9'd384;
      cmd_bm_q    <= 8'd133;
      cmd_em_q    <= 8'd132;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_ROW_BYTES:  row_bytes_q <= cfg_data_i[5:0];
        CFG_PRINTHEAD:  ph_q        <= cfg_data_i;
        CFG_CMD_BITMAP: cmd_bm_q    <= cfg_data_i[7:0];
        CFG_CMD_EMPTY:  cmd_em_q    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (row_bytes_q == 6'd0) begin
      eff_len = PW'(1);
    end else if (row_bytes_q > 6'(MAX_ROW_BYTES)) begin
      eff_len = PW'(MAX_ROW_BYTES);
    end else begin
      eff_len = PW'(row_bytes_q);
    end
  end

  assign third    = third_of(ph_q);
  assign third7   = 7'(third);
  assign third2_7 = 7'({third, 1'b0});
  assign third3_7 = third2_7 + third7;
  assign pos7     = 7'(pos_q);
  assign eff7     = 7'(eff_len);
  assign seg      = 2'(pos7 >= third7) + 2'(pos7 >= third2_7);
  assign pc       = popcount8(b_q);
  assign split    = (third != 5'd0) && (eff7 <= third3_7);

  // run packet description, stable while a packet is sent
  always_comb begin
    desc.blank     = run_blank_q;
    desc.cmd       = run_blank_q ? cmd_em_q : cmd_bm_q;
    desc.pay_len   = run_blank_q ? 8'd2 : 8'd6 + 8'(eff_len);
    desc.start_row = run_start_q;
    desc.cnt0      = split ? run_cnt_q[0][7:0] : 8'd0;
    desc.cnt1      = split ? run_cnt_q[1][7:0] : run_cnt_q[3][7:0];
    desc.cnt2      = split ? run_cnt_q[2][7:0] : {7'd0, run_cnt_q[3][8]};
    desc.run_len   = run_len_q;
  end

  assign in_stall_o = (st_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign wr_en      = accept && !func_i;
  assign wr_to1     = !run_bank_q[pos_q[AW-1:0]];
  assign raddr      = (st_q == ST_EMIT) ? emit_addr : pos_q[AW-1:0];
  assign rd_run     = rsel_q ? rd1 : rd0;

  always_comb begin
    st_d        = st_q;
    run_open_d  = run_open_q;
    run_blank_d = run_blank_q;
    run_len_d   = run_len_q;
    run_start_d = run_start_q;
    row_cnt_d   = row_cnt_q;
    pos_d       = pos_q;
    match_d     = match_q;
    zero_d      = zero_q;
    run_cnt_d   = run_cnt_q;
    inc_cnt_d   = inc_cnt_q;
    run_bank_d  = run_bank_q;
    fresh_d     = fresh_q;
    eoi_d       = eoi_q;
    b_d         = b_q;
    emit_start  = 1'b0;
    do_install  = 1'b0;
    joins       = 1'b0;
    np          = pos_q + PW'(1);
    if (wr_en) begin
      fresh_d[pos_q[AW-1:0]] = 1'b1;
    end
    case (st_q)
      ST_IDLE: begin
        if (accept) begin
          if (func_i) begin
            if (run_open_q) begin
              emit_start = 1'b1;
              eoi_d      = 1'b1;
              st_d       = ST_EMIT;
            end else begin
              row_cnt_d = '0;
              pos_d     = '0;
              match_d   = 1'b1;
              zero_d    = 1'b1;
              inc_cnt_d = '0;
            end
          end else begin
            b_d  = pixel_byte_i;
            st_d = ST_CMP;
          end
        end
      end
      ST_CMP: begin
        match_d = match_q && (b_q == rd_run);
        zero_d  = zero_q && (b_q == 8'd0);
        if ((third != 5'd0) && (pos7 < third3_7)) begin
          inc_cnt_d[seg] = inc_cnt_q[seg] + 9'(pc);
        end
        inc_cnt_d[3] = inc_cnt_q[3] + 9'(pc);
        pos_d = np;
        st_d  = ST_IDLE;
        if (np >= eff_len) begin
          joins = run_open_q && (run_len_q < RunLimit) &&
                  (run_blank_q ? zero_d : (!zero_d && match_d));
          if (joins) begin
            run_len_d = run_len_q + 8'd1;
            row_cnt_d = row_cnt_q + 16'd1;
            pos_d     = '0;
            match_d   = 1'b1;
            zero_d    = 1'b1;
            inc_cnt_d = '0;
          end else if (run_open_q) begin
            emit_start = 1'b1;
            eoi_d      = 1'b0;
            st_d       = ST_EMIT;
          end else begin
            do_install = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (emit_stat.done) begin
          st_d = ST_IDLE;
          if (eoi_q) begin
            run_open_d = 1'b0;
            row_cnt_d  = '0;
            pos_d      = '0;
            match_d    = 1'b1;
            zero_d     = 1'b1;
            inc_cnt_d  = '0;
          end else begin
            do_install = 1'b1;
          end
        end
      end
      default: st_d = ST_IDLE;
    endcase
    // the finished row opens a new run; rewritten entries move to the other bank
    if (do_install) begin
      run_open_d  = 1'b1;
      run_blank_d = zero_d;
      run_len_d   = 8'd1;
      run_start_d = row_cnt_q;
      run_cnt_d   = inc_cnt_d;
      run_bank_d  = run_bank_q ^ fresh_q;
      fresh_d     = '0;
      row_cnt_d   = row_cnt_q + 16'd1;
      pos_d       = '0;
      match_d     = 1'b1;
      zero_d      = 1'b1;
      inc_cnt_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      run_open_q  <= 1'b0;
      run_blank_q <= 1'b0;
      run_len_q   <= '0;
      run_start_q <= '0;
      row_cnt_q   <= '0;
      pos_q       <= '0;
      match_q     <= 1'b1;
      zero_q      <= 1'b1;
      run_cnt_q   <= '0;
      inc_cnt_q   <= '0;
      run_bank_q  <= '0;
      fresh_q     <= '0;
      eoi_q       <= 1'b0;
    end else begin
      st_q        <= st_d;
      run_open_q  <= run_open_d;
      run_blank_q <= run_blank_d;
      run_len_q   <= run_len_d;
      run_start_q <= run_start_d;
      row_cnt_q   <= row_cnt_d;
      pos_q       <= pos_d;
      match_q     <= match_d;
      zero_q      <= zero_d;
      run_cnt_q   <= run_cnt_d;
      inc_cnt_q   <= inc_cnt_d;
      run_bank_q  <= run_bank_d;
      fresh_q     <= fresh_d;
      eoi_q       <= eoi_d;
    end
  end

  // bank select follows the read address so it lines up with the ram data
  always_ff @(posedge clk_i) begin
    b_q    <= b_d;
    rsel_q <= run_bank_q[raddr];
  end

  // incoming byte lands in the bank that does not hold that run entry
  lrpe_ram #(
    .WIDTH(8),
    .DEPTH(MAX_ROW_BYTES)
  ) u_bank0 (
    .clk_i   (clk_i),
    .we_i    (wr_en && !wr_to1),
    .waddr_i (pos_q[AW-1:0]),
    .wdata_i (pixel_byte_i),
    .raddr_i (raddr),
    .rdata_o (rd0)
  );

  lrpe_ram #(
    .WIDTH(8),
    .DEPTH(MAX_ROW_BYTES)
  ) u_bank1 (
    .clk_i   (clk_i),
    .we_i    (wr_en && wr_to1),
    .waddr_i (pos_q[AW-1:0]),
    .wdata_i (pixel_byte_i),
    .raddr_i (raddr),
    .rdata_o (rd1)
  );

  lrpe_emit #(
    .AW(AW)
  ) u_emit (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (emit_start),
    .desc_i           (desc),
    .rdata_i          (rd_run),
    .raddr_o          (emit_addr),
    .stat_o           (emit_stat),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_byte_o       (out_byte_o),
    .last_of_packet_o (last_of_packet_o)
  );

  a_open_has_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_open_q |-> run_len_q != 8'd0)
    else $error("open run with zero length");

  a_done_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_stat.done |-> st_q == ST_EMIT)
    else $error("packet finished outside emit state");

  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_start |=> emit_stat.busy)
    else $error("packet start did not engage sequencer");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PW'(MAX_ROW_BYTES))
    else $error("byte position beyond row store");

endmodule

/* design/lrpe_ram.sv */
// generic single-write single-read ram with registered read data
module lrpe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 48
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/lrpe_emit.sv */
// packet sequencer: frames one run packet into bytes behind an output register
module lrpe_emit #(
  parameter int unsigned AW = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  lrpe_pkg::pkt_desc_t desc_i,
  input  logic [7:0]          rdata_i,
  output logic [AW-1:0]       raddr_o,
  output lrpe_pkg::emit_stat_t stat_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          out_byte_o,
  output logic                last_of_packet_o
);
  import lrpe_pkg::*;

  emit_state_e st_q, st_d;
  logic [6:0]  idx_q, idx_d;
  logic [7:0]  chk_q, chk_d;
  logic        ov_q, ov_d;
  logic [7:0]  ob_q, ob_d;
  logic        ol_q, ol_d;
  logic        done;

  logic [6:0] n7;
  logic [6:0] p;
  logic [7:0] cur;
  logic       cur_last;
  logic       in_chk;

  assign n7 = desc_i.pay_len[6:0];
  assign p  = idx_q - 7'd4;
  assign raddr_o = AW'(p - 7'd6);

  always_comb begin
    cur      = SyncTail;
    cur_last = (idx_q == n7 + 7'd6);
    in_chk   = (idx_q >= 7'd2) && (idx_q < n7 + 7'd4);
    if (idx_q < 7'd2) begin
      cur = SyncHead;
    end else if (idx_q == 7'd2) begin
      cur = desc_i.cmd;
    end else if (idx_q == 7'd3) begin
      cur = desc_i.pay_len;
    end else if (idx_q < n7 + 7'd4) begin
      if (desc_i.blank) begin
        cur = (p == 7'd0) ? 8'd0 : desc_i.run_len;
      end else begin
        case (p)
          7'd0:    cur = desc_i.start_row[15:8];
          7'd1:    cur = desc_i.start_row[7:0];
          7'd2:    cur = desc_i.cnt0;
          7'd3:    cur = desc_i.cnt1;
          7'd4:    cur = desc_i.cnt2;
          7'd5:    cur = desc_i.run_len;
          default: cur = rdata_i;
        endcase
      end
    end else if (idx_q == n7 + 7'd4) begin
      cur = chk_q;
    end
  end

  always_comb begin
    st_d  = st_q;
    idx_d = idx_q;
    chk_d = chk_q;
    ov_d  = ov_q;
    ob_d  = ob_q;
    ol_d  = ol_q;
    done  = 1'b0;
    if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end
    case (st_q)
      EM_IDLE: begin
        if (start_i) begin
          idx_d = '0;
          chk_d = '0;
          st_d  = EM_RD;
        end
      end
      EM_RD: begin
        // ram address settles from idx, data valid next cycle
        st_d = EM_OUT;
      end
      EM_OUT: begin
        if (!ov_q || !out_stall_i) begin
          ov_d = 1'b1;
          ob_d = cur;
          ol_d = cur_last;
          if (in_chk) begin
            chk_d = chk_q ^ cur;
          end
          if (cur_last) begin
            done = 1'b1;
            st_d = EM_IDLE;
          end else begin
            idx_d = idx_q + 7'd1;
            st_d  = EM_RD;
          end
        end
      end
      default: st_d = EM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= EM_IDLE;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    chk_q <= chk_d;
    ob_q  <= ob_d;
    ol_q  <= ol_d;
  end

  assign stat_o.busy      = (st_q != EM_IDLE);
  assign stat_o.done      = done;
  assign out_valid_o      = ov_q;
  assign out_byte_o       = ob_q;
  assign last_of_packet_o = ol_q;

endmodule
